FILE: hdl/fca_pkg.sv
// Shared types, constants and helpers for the allocation table chain allocator.
// No dependencies; imported by the engine, the top level and the checker.
package fca_pkg;

    localparam int FAT_DEPTH = 1024;
    localparam int ADDR_W    = 10;
    localparam int ENT_W     = 11;
    localparam int BYTES_W   = 24;
    localparam int LIM_W     = BYTES_W + 1;

    localparam logic [ENT_W-1:0] END_MARK    = {ENT_W{1'b1}};
    localparam logic [ENT_W-1:0] FAT_DEPTH_N = ENT_W'(FAT_DEPTH);

    localparam logic [1:0] KIND_ALLOC    = 2'd0;
    localparam logic [1:0] KIND_EXTEND   = 2'd1;
    localparam logic [1:0] KIND_SEEK     = 2'd2;
    localparam logic [1:0] KIND_TRUNCATE = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_SHORT = 2'd2;

    localparam logic CFG_FAT_ENTRIES = 1'b0;
    localparam logic CFG_BLOCK_LOG2  = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  start_block;
        logic [BYTES_W-1:0] byte_count;
        logic [ADDR_W-1:0]  block_count;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block;
        logic [ENT_W-1:0]  blocks_linked;
        logic [1:0]        status;
    } rsp_t;

    // Successor of a table entry, or zero when the entry ends the chain, is free or lies outside the usable range.
    function automatic logic [ADDR_W-1:0] next_of(input logic [ENT_W-1:0] ent,
                                                  input logic [ENT_W-1:0] n);
        logic [ADDR_W-1:0] res;
        res = ent[ADDR_W-1:0];
        if (ent == END_MARK || ent == '0 || ent >= n)
        begin
            res = '0;
        end
        return res;
    endfunction

endpackage

FILE: hdl/fat_chain_allocator.sv
// Top level of the allocation table chain allocator: configuration registers,
// output register and the table engine. Depends on fca_pkg and fca_engine.
//
// Usage:
//   Request words (kind, start_block, byte_count, block_count) enter on the
//   in_valid / in_ready channel; one result word (block, blocks_linked,
//   status) leaves on out_valid / out_ready for every request.
//   Configuration words on cfg_valid / cfg_ready / cfg_index / cfg_data set
//   the usable entry count and the block size; write them only while idle.
//   After reset the table is swept to free, one entry a cycle, all 1024
//   entries; in_ready stays low meanwhile, configuration is taken as ever.
//   The table sits in a single-port memory, one access per cycle, and each
//   entry visited takes a read state and then a check-and-write state; only
//   one request is in work.
//   A finished result waits in the output register; hold out_ready low and
//   the engine parks its next result until the register drains, while the
//   next request may still be accepted as soon as the engine is idle.
module fat_chain_allocator
    import fca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [ADDR_W-1:0]  start_block,
    input  logic [BYTES_W-1:0] byte_count,
    input  logic [ADDR_W-1:0]  block_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  block,
    output logic [ENT_W-1:0]   blocks_linked,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [ENT_W-1:0]   cfg_data
);

    logic [ENT_W-1:0]  fat_entries_reg;
    logic [4:0]        bs_log2_reg;
    logic [ENT_W-1:0]  n;
    req_t              req;
    rsp_t              rsp;
    logic              rsp_valid;
    logic              rsp_ready;
    logic              out_valid_reg;
    rsp_t              out_reg;

    // Clamp the usable entry count to the table depth.
    assign n = (fat_entries_reg > FAT_DEPTH_N) ? FAT_DEPTH_N : fat_entries_reg;

    assign req.kind        = kind;
    assign req.start_block = start_block;
    assign req.byte_count  = byte_count;
    assign req.block_count = block_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_entries_reg <= FAT_DEPTH_N;
            bs_log2_reg     <= 5'd10;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_FAT_ENTRIES)
            begin
                fat_entries_reg <= cfg_data;
            end
            else
            begin
                bs_log2_reg <= cfg_data[4:0];
            end
        end
    end

    fca_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n),
        .bs_log2   (bs_log2_reg),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Take a new result when the output register is empty or draining.
    assign rsp_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_ready && rsp_valid)
        begin
            out_reg <= rsp;
        end
    end

    assign out_valid     = out_valid_reg;
    assign block         = out_reg.block;
    assign blocks_linked = out_reg.blocks_linked;
    assign status        = out_reg.status;

endmodule

FILE: hdl/fca_engine.sv
// Sequencer and table memory: sweeps the table at reset, walks chains, scans for free entries
// and frees truncated tails, one table access per cycle. Depends on fca_pkg.
module fca_engine
    import fca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ENT_W-1:0] n,
    input  logic [4:0]       bs_log2,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN_RD, ST_SCAN_CK, ST_APPEND, ST_WALK_RD, ST_WALK_CK,
        ST_SEEK, ST_SEEK_CK, ST_TR, ST_TR_CK, ST_TR_END_CK, ST_FREE, ST_FREE_CK, ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  cur_reg, cur_next;
    logic [ENT_W-1:0]   ptr_reg, ptr_next;
    logic [ENT_W-1:0]   step_reg, step_next;
    logic [ENT_W-1:0]   linked_reg, linked_next;
    logic [LIM_W-1:0]   lim_reg, lim_next;
    logic [ADDR_W-1:0]  blk_reg, blk_next;
    logic [1:0]         status_reg, status_next;
    logic               first_reg, first_next;

    logic [ENT_W-1:0]   fat_mem [FAT_DEPTH];
    logic [ENT_W-1:0]   mem_q;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENT_W-1:0]   mem_wdata;

    logic [BYTES_W-1:0] quot;
    logic [BYTES_W-1:0] rem_mask;
    logic [LIM_W-1:0]   needed;
    logic               start_ok;
    logic [ADDR_W-1:0]  nx;
    logic               step_lt_lim;

    assign quot        = req.byte_count >> bs_log2;
    assign rem_mask    = ~({BYTES_W{1'b1}} << bs_log2);
    assign needed      = {1'b0, quot} + LIM_W'(|(req.byte_count & rem_mask));
    assign start_ok    = (req.start_block != '0) && ({1'b0, req.start_block} < n);
    assign nx          = next_of(mem_q, n);
    assign step_lt_lim = {{(LIM_W-ENT_W){1'b0}}, step_reg} < lim_reg;

    assign req_ready          = (state_reg == ST_IDLE);
    assign rsp_valid          = (state_reg == ST_DONE);
    assign rsp.block          = blk_reg;
    assign rsp.blocks_linked  = linked_reg;
    assign rsp.status         = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        ptr_next    = ptr_reg;
        step_next   = step_reg;
        linked_next = linked_reg;
        lim_next    = lim_reg;
        blk_next    = blk_reg;
        status_next = status_reg;
        first_next  = first_reg;
        mem_we      = 1'b0;
        mem_addr    = cur_reg;
        mem_wdata   = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = ptr_reg[ADDR_W-1:0];
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == FAT_DEPTH_N - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    blk_next    = '0;
                    linked_next = '0;
                    status_next = STAT_OK;
                    step_next   = '0;
                    first_next  = 1'b0;
                    cur_next    = req.start_block;
                    lim_next    = LIM_W'(req.block_count);
                    state_next  = ST_DONE;
                    case (req.kind)
                        KIND_ALLOC:
                        begin
                            lim_next   = needed;
                            ptr_next   = ENT_W'(1);
                            cur_next   = '0;
                            first_next = 1'b1;
                            state_next = ST_SCAN_RD;
                        end
                        KIND_EXTEND:
                        begin
                            if (start_ok)
                            begin
                                state_next = ST_WALK_RD;
                            end
                        end
                        KIND_SEEK:
                        begin
                            lim_next = {1'b0, quot};
                            if (start_ok)
                            begin
                                state_next = ST_SEEK;
                            end
                            else
                            begin
                                status_next = STAT_SHORT;
                            end
                        end
                        default:
                        begin
                            if (start_ok)
                            begin
                                state_next = ST_TR;
                            end
                        end
                    endcase
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_CK;
            end
            ST_WALK_CK:
            begin
                if (nx != '0 && step_reg < n)
                begin
                    cur_next   = nx;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    ptr_next   = ENT_W'(1);
                    step_next  = '0;
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (step_lt_lim)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = END_MARK;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN_RD:
            begin
                if (ptr_reg >= n)
                begin
                    // table full: close the chain at the last block taken
                    status_next = STAT_FULL;
                    mem_we      = !first_reg;
                    mem_wdata   = END_MARK;
                    state_next  = ST_DONE;
                end
                else
                begin
                    mem_addr   = ptr_reg[ADDR_W-1:0];
                    state_next = ST_SCAN_CK;
                end
            end
            ST_SCAN_CK:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (mem_q == '0 && ptr_reg[ADDR_W-1:0] != cur_reg)
                begin
                    if (first_reg)
                    begin
                        blk_next    = ptr_reg[ADDR_W-1:0];
                        linked_next = ENT_W'(1);
                        first_next  = 1'b0;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        mem_wdata   = {1'b0, ptr_reg[ADDR_W-1:0]};
                        linked_next = linked_reg + 1'b1;
                        step_next   = step_reg + 1'b1;
                    end
                    cur_next   = ptr_reg[ADDR_W-1:0];
                    state_next = ST_APPEND;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SEEK:
            begin
                if (step_lt_lim)
                begin
                    state_next = ST_SEEK_CK;
                end
                else
                begin
                    blk_next   = cur_reg;
                    state_next = ST_DONE;
                end
            end
            ST_SEEK_CK:
            begin
                if (nx == '0 || step_reg >= n)
                begin
                    status_next = STAT_SHORT;
                    blk_next    = cur_reg;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cur_next   = nx;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_SEEK;
                end
            end
            ST_TR:
            begin
                state_next = step_lt_lim ? ST_TR_CK : ST_TR_END_CK;
            end
            ST_TR_CK:
            begin
                if (nx == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cur_next   = nx;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_TR;
                end
            end
            ST_TR_END_CK:
            begin
                if (nx == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = END_MARK;
                    cur_next   = nx;
                    state_next = ST_FREE;
                end
            end
            ST_FREE:
            begin
                state_next = (linked_reg < n) ? ST_FREE_CK : ST_DONE;
            end
            ST_FREE_CK:
            begin
                mem_we      = 1'b1;
                linked_next = linked_reg + 1'b1;
                cur_next    = nx;
                state_next  = (nx == '0) ? ST_DONE : ST_FREE;
            end
            ST_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            cur_reg    <= '0;
            step_reg   <= '0;
            linked_reg <= '0;
            lim_reg    <= '0;
            blk_reg    <= '0;
            status_reg <= STAT_OK;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            cur_reg    <= cur_next;
            step_reg   <= step_next;
            linked_reg <= linked_next;
            lim_reg    <= lim_next;
            blk_reg    <= blk_next;
            status_reg <= status_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fat_mem[mem_addr] <= mem_wdata;
        end
        else
        begin
            mem_q <= fat_mem[mem_addr];
        end
    end

endmodule

FILE: hdl/fca_checker.sv
// Port-level checks for the chain allocator, bound to the top level.
// Depends on fca_pkg.
module fca_checker
    import fca_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ADDR_W-1:0] block,
    input logic [ENT_W-1:0]  blocks_linked,
    input logic [1:0]        status
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block) && $stable(status)
            && $stable(blocks_linked))
        else $error("result word changed while stalled");

    // one request at a time: the sequencer is busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STAT_OK || status == STAT_FULL || status == STAT_SHORT)
        else $error("undefined status code");

    // a short chain only comes from a seek, which links nothing
    a_seek_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_SHORT |-> blocks_linked == '0)
        else $error("seek reported linked blocks");

    a_linked_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blocks_linked <= FAT_DEPTH_N)
        else $error("linked count beyond table depth");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);
